[src/tkct_pkg.sv]
// shared types and constants for the top-k candidate tracker
package tkct_pkg;

  localparam int KEEP_COUNT = 5;
  localparam int SCORE_W    = 16;
  localparam int INDEX_W    = 16;
  localparam int COUNT_W    = $clog2(KEEP_COUNT + 1);

  typedef enum logic {
    FUNC_OFFER = 1'b0,
    FUNC_CLEAR = 1'b1
  } tkct_func_t;

  typedef struct packed {
    tkct_func_t         func;
    logic [SCORE_W-1:0] cand_score;
    logic [INDEX_W-1:0] cand_index;
  } tkct_cand_t;

  typedef struct packed {
    logic               accepted;
    logic               was_duplicate;
    logic [COUNT_W-1:0] held_count;
    logic [INDEX_W-1:0] rank0_index;
    logic [INDEX_W-1:0] rank1_index;
    logic [INDEX_W-1:0] rank2_index;
    logic [INDEX_W-1:0] rank3_index;
    logic [INDEX_W-1:0] rank4_index;
  } tkct_res_t;

  typedef struct packed {
    logic [KEEP_COUNT-1:0][SCORE_W-1:0] score;
    logic [KEEP_COUNT-1:0][INDEX_W-1:0] index;
  } tkct_list_t;

  typedef struct packed {
    logic               accepted;
    logic               dup;
    logic [COUNT_W-1:0] count;
  } tkct_verdict_t;

endpackage

[src/tkct_insert.sv]
// one-pass duplicate check and sorted insertion into the ranked list
module tkct_insert import tkct_pkg::*; (
  input  tkct_list_t    list_cur,
  input  logic [COUNT_W-1:0] count_cur,
  input  tkct_cand_t    cand,
  output tkct_list_t    list_upd,
  output tkct_verdict_t verdict
);

  logic [KEEP_COUNT-1:0] held;
  logic [KEEP_COUNT-1:0] ge;
  logic [KEEP_COUNT-1:0] hit;
  logic                  room;
  logic                  beats_worst;
  logic                  dup;
  logic                  take;

  always_comb begin
    for (int i = 0; i < KEEP_COUNT; i++) begin
      held[i] = COUNT_W'(i) < count_cur;
      ge[i]   = held[i] && (list_cur.score[i] >= cand.cand_score);
      hit[i]  = held[i] && (list_cur.index[i] == cand.cand_index);
    end
  end

  assign room        = count_cur < COUNT_W'(KEEP_COUNT);
  assign beats_worst = cand.cand_score > list_cur.score[KEEP_COUNT-1];
  assign dup         = (cand.func == FUNC_OFFER) && (|hit);
  assign take        = (cand.func == FUNC_OFFER) && !dup && (room || beats_worst);

  // entries at or above the new score stay, the new one lands after them,
  // everything below slides down one place
  always_comb begin
    logic               prev_ge;
    logic [SCORE_W-1:0] prev_score;
    logic [INDEX_W-1:0] prev_index;
    list_upd   = list_cur;
    prev_ge    = 1'b1;
    prev_score = '0;
    prev_index = '0;
    if (take) begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
        if (ge[i]) begin
          list_upd.score[i] = list_cur.score[i];
          list_upd.index[i] = list_cur.index[i];
        end else if (prev_ge) begin
          list_upd.score[i] = cand.cand_score;
          list_upd.index[i] = cand.cand_index;
        end else begin
          list_upd.score[i] = prev_score;
          list_upd.index[i] = prev_index;
        end
        prev_ge    = ge[i];
        prev_score = list_cur.score[i];
        prev_index = list_cur.index[i];
      end
    end
  end

  always_comb begin
    verdict.accepted = take;
    verdict.dup      = dup;
    if (cand.func == FUNC_CLEAR) begin
      verdict.count = '0;
    end else if (take && room) begin
      verdict.count = count_cur + COUNT_W'(1);
    end else begin
      verdict.count = count_cur;
    end
  end

endmodule

[src/top_k_candidate_tracker.sv]
// top-k candidate tracker: keeps the five best (score, index) offers in rank order
//
// cand channel: one transaction per item; func selects an offer or a clear of
// the list. An offer whose index is already held is flagged and dropped; an
// offer into a full list replaces the worst entry only when its score is
// strictly higher. Ties keep the earlier arrival ahead.
// res channel: exactly one transaction per item, carrying accepted,
// was_duplicate, held_count and the five ranked indices (zero where unheld).
// Throughput is one item per cycle while res_stall does not hold the result: the duplicate search and the insertion
// compare against all five entries at once, between the input register and
// the result register. res_valid rises when an item's result is loaded from
// the input register into the result register.
// When res_stall is held the result register keeps its transaction, one more
// item waits in the input register, and then cand_stall rises.
// Reset empties the list and drops any item in flight; the stored scores and
// indices are not cleared and are never shown while unheld.
module top_k_candidate_tracker import tkct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cand_valid,
  output logic       cand_stall,
  input  tkct_cand_t cand,
  output logic       res_valid,
  input  logic       res_stall,
  output tkct_res_t  res
);

  logic               stage_valid;
  tkct_cand_t         stage;
  tkct_list_t         list;
  logic [COUNT_W-1:0] count;

  tkct_list_t    list_next;
  tkct_verdict_t verdict;
  logic          res_free;
  logic          proc;
  logic          take_cand;
  logic [KEEP_COUNT-1:0][INDEX_W-1:0] rank;
  logic          sorted_ok;

  assign res_free   = !res_valid || !res_stall;
  assign proc       = stage_valid && res_free;
  assign cand_stall = stage_valid && !res_free;
  assign take_cand  = cand_valid && !cand_stall;

  tkct_insert u_insert (
    .list_cur (list),
    .count_cur(count),
    .cand     (stage),
    .list_upd (list_next),
    .verdict  (verdict)
  );

  always_comb begin
    for (int j = 0; j < KEEP_COUNT; j++) begin
      rank[j] = (COUNT_W'(j) < verdict.count) ? list_next.index[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take_cand) begin
      stage_valid <= 1'b1;
    end else if (proc) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_cand) begin
      stage <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (proc) begin
      count <= verdict.count;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      list <= list_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res.accepted      <= verdict.accepted;
      res.was_duplicate <= verdict.dup;
      res.held_count    <= verdict.count;
      res.rank0_index   <= rank[0];
      res.rank1_index   <= rank[1];
      res.rank2_index   <= rank[2];
      res.rank3_index   <= rank[3];
      res.rank4_index   <= rank[4];
    end
  end

  // held entries must stay in descending score order
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < KEEP_COUNT; i++) begin
      if (COUNT_W'(i) < count && list.score[i] > list.score[i-1]) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(KEEP_COUNT))
    else $error("held count above list depth");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    sorted_ok)
    else $error("ranked list out of order");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (proc && stage.func == FUNC_CLEAR) |=> (count == '0))
    else $error("clear left entries held");

  a_dup_not_taken: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.accepted && res.was_duplicate))
    else $error("duplicate offer entered the list");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (proc && verdict.accepted) |=>
      (count == $past(count) || count == $past(count) + COUNT_W'(1)))
    else $error("insertion changed count by more than one");

endmodule
